// ===== rtl/core/mkpc_pkg.sv =====
// Shared types, constants and codes for the multi-key press classifier.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package mkpc_pkg;

  localparam int NumKeys = 8;
  localparam int KeyW    = 3;
  localparam int WideW   = 12;
  localparam int HoldW   = 8;
  localparam int LongW   = 11;
  localparam int ClickW  = 3;
  localparam int PendW   = 3;
  localparam int ModeW   = 4;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 3;

  localparam logic [WideW-1:0]  WideMax  = 12'hFFE;
  localparam logic [HoldW-1:0]  HoldMax  = 8'hFE;
  localparam logic [ClickW-1:0] ClickMax = 3'd7;
  localparam logic [ClickW-1:0] ClickDbl = 3'd2;

  // Request kinds.
  localparam logic ReqTick = 1'b0;
  localparam logic ReqScan = 1'b1;

  // Mode bit positions within a key's nibble.
  localparam int ModeShort  = 0;
  localparam int ModeLong   = 1;
  localparam int ModeRepeat = 2;
  localparam int ModeDouble = 3;

  // Pending event codes.
  localparam logic [PendW-1:0] PendNone   = 3'd0;
  localparam logic [PendW-1:0] PendShort  = 3'd1;
  localparam logic [PendW-1:0] PendLong   = 3'd2;
  localparam logic [PendW-1:0] PendDouble = 3'd4;

  typedef enum logic [1:0] {
    EvShort  = 2'd0,
    EvLong   = 2'd1,
    EvRepeat = 2'd2,
    EvDouble = 2'd3
  } ev_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegModeTable = 3'd0,
    RegLevelMask = 3'd1,
    RegDebounce  = 3'd2,
    RegLong      = 3'd3,
    RegGap       = 3'd4,
    RegRepeat    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [NumKeys*ModeW-1:0] mode_table;
    logic [NumKeys-1:0]       level_mask;
    logic [WideW-1:0]         debounce_ticks;
    logic [LongW-1:0]         long_ticks;
    logic [WideW-1:0]         gap_ticks;
    logic [HoldW-1:0]         repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic              was_pressed;
    logic [WideW-1:0]  press_timer;
    logic              press_timing;
    logic [WideW-1:0]  gap_timer;
    logic              gap_timing;
    logic [HoldW-1:0]  hold_timer;
    logic              hold_timing;
    logic [ClickW-1:0] click_count;
    logic [PendW-1:0]  pending_event;
  } key_state_t;

  typedef struct packed {
    logic     valid;
    ev_code_e code;
  } event_t;

  function automatic ev_code_e pend_to_code(logic [PendW-1:0] p);
    ev_code_e c;
    c = EvShort;
    if (p == PendLong) c = EvLong;
    if (p == PendDouble) c = EvDouble;
    return c;
  endfunction

endpackage

// ===== rtl/core/mkpc_cfg_regs.sv =====
// Configuration register file of the press classifier.
// Depends on mkpc_pkg for register indexes, widths and the cfg_t bundle.
`timescale 1ns / 1ps

module mkpc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mkpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mkpc_pkg::CfgDataW-1:0] cfg_data_i,
  output mkpc_pkg::cfg_t               cfg_o
);

  mkpc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_table     <= '0;
      cfg_q.level_mask     <= '0;
      cfg_q.debounce_ticks <= mkpc_pkg::WideW'(20);
      cfg_q.long_ticks     <= mkpc_pkg::LongW'(1000);
      cfg_q.gap_ticks      <= mkpc_pkg::WideW'(300);
      cfg_q.repeat_ticks   <= mkpc_pkg::HoldW'(100);
    end else if (cfg_we_i) begin
      case (mkpc_pkg::cfg_idx_e'(cfg_idx_i))
        mkpc_pkg::RegModeTable: begin
          cfg_q.mode_table <= cfg_data_i[mkpc_pkg::NumKeys*mkpc_pkg::ModeW-1:0];
        end
        mkpc_pkg::RegLevelMask: begin
          cfg_q.level_mask <= cfg_data_i[mkpc_pkg::NumKeys-1:0];
        end
        mkpc_pkg::RegDebounce: begin
          cfg_q.debounce_ticks <= cfg_data_i[mkpc_pkg::WideW-1:0];
        end
        mkpc_pkg::RegLong: begin
          cfg_q.long_ticks <= cfg_data_i[mkpc_pkg::LongW-1:0];
        end
        mkpc_pkg::RegGap: begin
          cfg_q.gap_ticks <= cfg_data_i[mkpc_pkg::WideW-1:0];
        end
        mkpc_pkg::RegRepeat: begin
          cfg_q.repeat_ticks <= cfg_data_i[mkpc_pkg::HoldW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/mkpc_key_unit.sv =====
// Shared per-key update unit: advances one key's timers for a tick or
// classifies one scan. Depends on mkpc_pkg for key_state_t, cfg_t and codes.
`timescale 1ns / 1ps

module mkpc_key_unit (
  input  logic                        is_tick_i,
  input  logic                        pin_i,
  input  logic                        active_i,
  input  logic [mkpc_pkg::ModeW-1:0]  mode_i,
  input  mkpc_pkg::cfg_t              cfg_i,
  input  mkpc_pkg::key_state_t        st_i,
  output mkpc_pkg::key_state_t        st_o,
  output mkpc_pkg::event_t            ev_o
);

  logic                      m_short, m_long, m_rep, m_dbl;
  logic [mkpc_pkg::WideW-1:0] twice;
  logic [mkpc_pkg::WideW-1:0] long_ext;

  assign m_short  = mode_i[mkpc_pkg::ModeShort];
  assign m_long   = mode_i[mkpc_pkg::ModeLong];
  assign m_rep    = mode_i[mkpc_pkg::ModeRepeat];
  assign m_dbl    = mode_i[mkpc_pkg::ModeDouble];
  assign twice    = {cfg_i.long_ticks, 1'b0};
  assign long_ext = {1'b0, cfg_i.long_ticks};

  always_comb begin
    st_o       = st_i;
    ev_o.valid = 1'b0;
    ev_o.code  = mkpc_pkg::EvShort;

    if (is_tick_i) begin
      if (st_i.press_timing && st_i.press_timer < mkpc_pkg::WideMax) begin
        st_o.press_timer = st_i.press_timer + 1'b1;
      end
      if (st_i.gap_timing && st_i.gap_timer < mkpc_pkg::WideMax) begin
        st_o.gap_timer = st_i.gap_timer + 1'b1;
      end
      if (st_i.hold_timing && st_i.hold_timer < mkpc_pkg::HoldMax) begin
        st_o.hold_timer = st_i.hold_timer + 1'b1;
      end
    end else if (pin_i == active_i) begin
      if (!st_i.was_pressed) begin
        st_o.press_timer  = '0;
        st_o.press_timing = 1'b1;
        if (m_dbl) begin
          st_o.gap_timing = 1'b0;
          if (st_i.gap_timer <= cfg_i.gap_ticks) begin
            if (st_i.click_count < mkpc_pkg::ClickMax) begin
              st_o.click_count = st_i.click_count + 1'b1;
            end
          end else begin
            st_o.click_count = '0;
          end
          st_o.gap_timer = '0;
        end
      end else if (m_rep && st_i.press_timer >= twice) begin
        st_o.hold_timing = 1'b1;
        if (st_i.hold_timer > cfg_i.repeat_ticks) begin
          st_o.hold_timer    = '0;
          st_o.pending_event = mkpc_pkg::PendNone;
          ev_o.valid         = 1'b1;
          ev_o.code          = mkpc_pkg::EvRepeat;
        end
      end
      st_o.was_pressed = 1'b1;
    end else begin
      st_o.press_timing = 1'b0;
      if (st_i.was_pressed) begin
        // Later checks override earlier ones: short, then long, then double.
        if (m_short && st_i.press_timer >= cfg_i.debounce_ticks &&
            st_i.press_timer < long_ext) begin
          st_o.pending_event = mkpc_pkg::PendShort;
        end
        if (m_long && st_i.press_timer >= long_ext &&
            (!m_rep || st_i.press_timer < twice)) begin
          st_o.pending_event = mkpc_pkg::PendLong;
        end
        if (m_rep) begin
          st_o.gap_timer   = '0;
          st_o.hold_timing = 1'b0;
        end
        if (m_dbl) begin
          st_o.gap_timer  = '0;
          st_o.gap_timing = 1'b1;
          if (st_i.click_count == mkpc_pkg::ClickDbl) begin
            st_o.pending_event = mkpc_pkg::PendDouble;
            st_o.click_count   = '0;
          end
        end
      end else if (m_dbl) begin
        if (st_i.gap_timer > cfg_i.gap_ticks) begin
          if (st_i.pending_event != mkpc_pkg::PendNone) begin
            ev_o.valid        = 1'b1;
            ev_o.code         = mkpc_pkg::pend_to_code(st_i.pending_event);
            st_o.press_timer  = '0;
          end
          st_o.pending_event = mkpc_pkg::PendNone;
          st_o.gap_timer     = '0;
          st_o.gap_timing    = 1'b0;
          st_o.click_count   = '0;
        end
      end else begin
        if (st_i.pending_event != mkpc_pkg::PendNone) begin
          ev_o.valid       = 1'b1;
          ev_o.code        = mkpc_pkg::pend_to_code(st_i.pending_event);
          st_o.press_timer = '0;
        end
        st_o.pending_event = mkpc_pkg::PendNone;
      end
      st_o.was_pressed = 1'b0;
    end
  end

endmodule

// ===== rtl/core/multi_key_press_classifier_core.sv =====
// Top level of the multi-key press classifier: sequencer, per-key state
// registers and output register. Depends on mkpc_pkg, mkpc_cfg_regs, mkpc_key_unit.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_ready_o) carries one request per beat:
// a tick that advances the press, gap and hold timers of every key, or a
// scan that gives one key's sampled pin level. The output channel
// (out_valid_o / out_ready_i) carries at most one event per scan beat:
// short press, long press, hold repeat or double click, with the key id.
// A tick is accepted and then walks the keys through the shared key unit,
// one key per cycle. A scan is accepted, then makes one pass through the
// key unit; an event appears on the output the cycle after that pass.
// The output register is separate from the sequencer, so a new beat is taken
// while an event waits. A scan only finishes its update once the output
// register is free; if the receiver stalls with an event still held, the
// scan waits in place and the input stays not ready.
// Reset clears all key state, empties the output register and loads the
// register defaults. Configuration writes are taken on any cycle and are
// expected only while the block is idle.

module multi_key_press_classifier_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mkpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mkpc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [mkpc_pkg::KeyW-1:0]      key_index_i,
  input  logic                           pin_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mkpc_pkg::KeyW-1:0]      key_id_o,
  output logic [1:0]                     event_code_o
);

  typedef enum logic [1:0] {
    StIdle,
    StTick,
    StScan
  } state_e;

  state_e                      state_q;
  logic [mkpc_pkg::KeyW-1:0]   idx_q;
  logic                        pin_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [mkpc_pkg::KeyW-1:0]   key_id_q;
  mkpc_pkg::ev_code_e          ev_code_q;
  mkpc_pkg::key_state_t        st_q [mkpc_pkg::NumKeys];

  mkpc_pkg::cfg_t              cfg;
  mkpc_pkg::key_state_t        st_nxt;
  mkpc_pkg::event_t            ev;
  logic                        in_fire;
  logic                        key_ok;
  logic                        out_free;

  mkpc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // One key unit serves every key; the sequencer index picks the entry.
  mkpc_key_unit u_key (
    .is_tick_i (state_q == StTick),
    .pin_i     (pin_q),
    .active_i  (cfg.level_mask[idx_q]),
    .mode_i    (cfg.mode_table[idx_q*mkpc_pkg::ModeW +: mkpc_pkg::ModeW]),
    .cfg_i     (cfg),
    .st_i      (st_q[idx_q]),
    .st_o      (st_nxt),
    .ev_o      (ev)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign key_ok     = {1'b0, key_index_i} < (mkpc_pkg::KeyW+1)'(mkpc_pkg::NumKeys);
  assign out_free   = !out_valid_q || out_ready_i;

  // The output register drains on a taken beat and refills when a scan
  // finishes with an event.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == StScan && out_free && ev.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      pin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      key_id_q    <= '0;
      ev_code_q   <= mkpc_pkg::EvShort;
      for (int i = 0; i < mkpc_pkg::NumKeys; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            pin_q <= pin_level_i;
            if (req_type_i == mkpc_pkg::ReqScan) begin
              idx_q <= key_index_i;
              // A scan of a key beyond the configured count is dropped.
              if (key_ok) begin
                state_q <= StScan;
              end
            end else begin
              idx_q   <= '0;
              state_q <= StTick;
            end
          end
        end
        StTick: begin
          st_q[idx_q] <= st_nxt;
          if (idx_q == mkpc_pkg::KeyW'(mkpc_pkg::NumKeys - 1)) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StScan: begin
          if (out_free) begin
            st_q[idx_q] <= st_nxt;
            if (ev.valid) begin
              key_id_q  <= idx_q;
              ev_code_q <= ev.code;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_id_o     = key_id_q;
  assign event_code_o = ev_code_q;

endmodule
